[hw/rtl/apt_pkg.sv]
package apt_pkg;

    localparam logic [1:0] MODE_ANNOUNCE = 2'd0;
    localparam logic [1:0] MODE_LOOKUP   = 2'd1;
    localparam logic [1:0] MODE_TICK     = 2'd2;

    localparam logic [2:0] ST_REFRESHED  = 3'd0;
    localparam logic [2:0] ST_ADDED      = 3'd1;
    localparam logic [2:0] ST_DROPPED    = 3'd2;
    localparam logic [2:0] ST_FOUND      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_TICK_DONE  = 3'd5;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] peer_address;
        logic [15:0] peer_source_port;
        logic [15:0] announced_tcp_port;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found_tcp_port;
        logic [4:0]  live_entries;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] source_port;
        logic [15:0] service_port;
        logic [31:0] last_seen;
    } entry_t;

    typedef struct packed {
        logic alive;
        logic key_hit;
        logic addr_hit;
    } entry_check_t;

endpackage

[hw/rtl/apt_entry_check.sv]
module apt_entry_check
    import apt_pkg::*;
(
    input  logic         entry_valid,
    input  entry_t       entry,
    input  logic [31:0]  seconds_now,
    input  logic [15:0]  timeout_seconds,
    input  logic [31:0]  peer_address,
    input  logic [15:0]  peer_source_port,
    output entry_check_t check
);

    logic [31:0] age;

    // age wraps modulo 2^32 along with the seconds counter
    assign age = seconds_now - entry.last_seen;

    always_comb begin
        check.alive    = entry_valid && (age < {16'd0, timeout_seconds});
        check.addr_hit = check.alive && (entry.address == peer_address);
        check.key_hit  = check.addr_hit && (entry.source_port == peer_source_port);
    end

endmodule

[hw/rtl/aging_peer_table.sv]
// Channel   | Ports                              | Beat
// ----------+------------------------------------+------------------------------------
// input     | s_valid, s_ready, s_data           | one announce, lookup or tick item
// result    | m_valid, m_ready, m_data           | one status beat per input beat
// config    | cfg_wr_en, cfg_wr_data             | timeout in seconds, no wait
//
// Each beat is captured, the entry memory is swept one entry a cycle through a registered
// read, a drain step waits for the last read, and the write-back is committed. The sweep
// of the entry memory sets the pace of the block; one beat is in work at a time.
// Reset (aresetn low, synchronous) clears all valid bits, the seconds counter and the
// timeout to 30; the memory contents need no clearing. A stalled result holds the commit
// stage, and a new input beat is taken as soon as the previous one has committed.
module aging_peer_table
    import apt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // control state
    logic [1:0]             state_reg, state_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]            seconds_reg, seconds_next;
    logic [15:0]            timeout_reg;
    logic [IW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   proc_vld_reg, proc_vld_next;
    logic [IW-1:0]          proc_idx_reg, proc_idx_next;
    logic                   hit_reg, hit_next;
    logic                   free_reg, free_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;

    // payload
    in_beat_t               item_reg, item_next;
    logic [IW-1:0]          hit_idx_reg, hit_idx_next;
    logic [15:0]            hit_port_reg, hit_port_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    out_beat_t              m_data_reg, m_data_next;

    // entry memory
    entry_t                 entry_mem [TABLE_DEPTH];
    entry_t                 rd_entry_reg;
    logic                   mem_we;
    logic [IW-1:0]          mem_wr_idx;
    entry_t                 mem_wr_entry;

    entry_check_t           check;
    logic                   commit;
    logic                   adding;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_wr_idx] <= mem_wr_entry;
        end
        rd_entry_reg <= entry_mem[rd_idx_reg];
    end

    apt_entry_check u_check (
        .entry_valid      (valid_reg[proc_idx_reg]),
        .entry            (rd_entry_reg),
        .seconds_now      (seconds_reg),
        .timeout_seconds  (timeout_reg),
        .peer_address     (item_reg.peer_address),
        .peer_source_port (item_reg.peer_source_port),
        .check            (check)
    );

    assign commit = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign adding = (item_reg.mode == MODE_ANNOUNCE) && !hit_reg && free_reg;

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        seconds_next  = seconds_reg;
        rd_idx_next   = rd_idx_reg;
        proc_vld_next = 1'b0;
        proc_idx_next = proc_idx_reg;
        hit_next      = hit_reg;
        free_next     = free_reg;
        cnt_next      = cnt_reg;
        item_next     = item_reg;
        hit_idx_next  = hit_idx_reg;
        hit_port_next = hit_port_reg;
        free_idx_next = free_idx_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_wr_idx    = free_idx_reg;
        mem_wr_entry  = '{address:      item_reg.peer_address,
                          source_port:  item_reg.peer_source_port,
                          service_port: item_reg.announced_tcp_port,
                          last_seen:    seconds_reg};

        // release the result slot when the beat is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // age, match and look for a free slot on the entry whose data just arrived
        if (proc_vld_reg) begin
            if (!check.alive) begin
                valid_next[proc_idx_reg] = 1'b0;
                if (!free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = proc_idx_reg;
                end
            end else begin
                cnt_next = cnt_reg + CW'(1);
            end
            if (!hit_reg) begin
                if ((item_reg.mode == MODE_ANNOUNCE && check.key_hit) ||
                    (item_reg.mode == MODE_LOOKUP && check.addr_hit)) begin
                    hit_next      = 1'b1;
                    hit_idx_next  = proc_idx_reg;
                    hit_port_next = rd_entry_reg.service_port;
                end
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next   = s_data;
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    cnt_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one read a cycle
                proc_vld_next = 1'b1;
                proc_idx_next = rd_idx_reg;
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = S_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + IW'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (commit) begin
                    m_valid_next               = 1'b1;
                    m_data_next.found_tcp_port = 16'd0;
                    m_data_next.live_entries   = 5'(cnt_reg);
                    case (item_reg.mode)
                        MODE_ANNOUNCE: begin
                            if (hit_reg) begin
                                mem_we                = 1'b1;
                                mem_wr_idx            = hit_idx_reg;
                                m_data_next.status    = ST_REFRESHED;
                            end else if (free_reg) begin
                                mem_we                   = 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                                m_data_next.status       = ST_ADDED;
                                m_data_next.live_entries = 5'(cnt_reg + CW'(adding));
                            end else begin
                                m_data_next.status = ST_DROPPED;
                            end
                        end
                        MODE_LOOKUP: begin
                            if (hit_reg) begin
                                m_data_next.status         = ST_FOUND;
                                m_data_next.found_tcp_port = hit_port_reg;
                            end else begin
                                m_data_next.status = ST_NOT_FOUND;
                            end
                        end
                        MODE_TICK: begin
                            seconds_next       = seconds_reg + 32'd1;
                            m_data_next.status = ST_TICK_DONE;
                        end
                        default: begin
                            m_data_next.status = ST_TICK_DONE;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            seconds_reg  <= '0;
            timeout_reg  <= TIMEOUT_RESET;
            rd_idx_reg   <= '0;
            proc_vld_reg <= 1'b0;
            proc_idx_reg <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            seconds_reg  <= seconds_next;
            rd_idx_reg   <= rd_idx_next;
            proc_vld_reg <= proc_vld_next;
            proc_idx_reg <= proc_idx_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        hit_idx_reg  <= hit_idx_next;
        hit_port_reg <= hit_port_next;
        free_idx_reg <= free_idx_next;
        m_data_reg   <= m_data_next;
    end

endmodule
